[design/p3bv_pkg.sv]
// ----------------------------------------------------------------------------
// p3bv_pkg
// Shared types and constants for the padded 3D bit volume store.
// ----------------------------------------------------------------------------
package p3bv_pkg;

    localparam int MAX_SIZE_X_DEF = 64;
    localparam int MAX_SIZE_Y_DEF = 64;
    localparam int MAX_SIZE_Z_DEF = 16;

    localparam int SIZE_X_RST = 64;
    localparam int SIZE_Y_RST = 64;
    localparam int SIZE_Z_RST = 16;

    localparam int OPCODE_W = 2;
    localparam int COORD_W = 8;
    localparam int SIZE_X_W = 7;
    localparam int SIZE_Y_W = 7;
    localparam int SIZE_Z_W = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 7;

    // Bits per memory word; a padded row always holds whole words.
    localparam int WORD_W = 8;
    localparam int WORD_SEL_W = 3;
    // Words per padded row, at most (127 + 7) / 8.
    localparam int ROW_WORDS_W = 5;
    // Row index y + size_y * z with y < 128 and z < 32.
    localparam int ROW_W = 13;
    // Word index row * words_per_row + x / 8.
    localparam int WADDR_W = ROW_W + ROW_WORDS_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SET       = 2'd0,
        OP_CLEAR     = 2'd1,
        OP_GET       = 2'd2,
        OP_CLEAR_ALL = 2'd3
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SIZE_X = 2'd0,
        CFG_SIZE_Y = 2'd1,
        CFG_SIZE_Z = 2'd2,
        CFG_UNUSED = 2'd3
    } cfg_index_t;

endpackage

[design/padded_3d_bit_volume.sv]
// ----------------------------------------------------------------------------
// padded_3d_bit_volume
// One bit per voxel volume store with set, clear, get and clear-all commands.
//
//   Channel   Direction  Ports                                   Transfer
//   s_        in         s_opcode, s_coord_x, s_coord_y, s_coord_z  valid & ready
//   m_        out        m_status, m_bit_value                   valid & ready
//   cfg_      in         cfg_index, cfg_data                     valid & ready
//
// A point command forms its row index (one multiply) as it is accepted, then
// the word address and the memory read in ST_ADDR; its write back in ST_RMW
// overlaps the acceptance of the next command, which is not taken in ST_ADDR.
// Clear-all sweeps the memory one 8-bit word per cycle, over all of its
// ceil(MAX_SIZE_X / 8) * MAX_SIZE_Y * MAX_SIZE_Z words (8192 at the defaults).
// After reset the same sweep runs with s_ready low; configuration writes are
// taken at all times. A stalled result holds the block in its write-back cycle.
// ----------------------------------------------------------------------------
module padded_3d_bit_volume
    import p3bv_pkg::*;
#(
    parameter int MAX_SIZE_X = MAX_SIZE_X_DEF,
    parameter int MAX_SIZE_Y = MAX_SIZE_Y_DEF,
    parameter int MAX_SIZE_Z = MAX_SIZE_Z_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [OPCODE_W-1:0]    s_opcode,
    input  logic [COORD_W-1:0]     s_coord_x,
    input  logic [COORD_W-1:0]     s_coord_y,
    input  logic [COORD_W-1:0]     s_coord_z,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_status,
    output logic                   m_bit_value,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int DEPTH = ((MAX_SIZE_X + WORD_W - 1) / WORD_W) * MAX_SIZE_Y * MAX_SIZE_Z;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    localparam logic [SIZE_X_W-1:0] SIZE_X_INIT =
        (SIZE_X_RST > MAX_SIZE_X) ? SIZE_X_W'(MAX_SIZE_X) : SIZE_X_W'(SIZE_X_RST);
    localparam logic [SIZE_Y_W-1:0] SIZE_Y_INIT =
        (SIZE_Y_RST > MAX_SIZE_Y) ? SIZE_Y_W'(MAX_SIZE_Y) : SIZE_Y_W'(SIZE_Y_RST);
    localparam logic [SIZE_Z_W-1:0] SIZE_Z_INIT =
        (SIZE_Z_RST > MAX_SIZE_Z) ? SIZE_Z_W'(MAX_SIZE_Z) : SIZE_Z_W'(SIZE_Z_RST);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_RMW,
        ST_CLEAR
    } state_t;

    state_t                  state_reg;
    logic [SIZE_X_W-1:0]     size_x_reg;
    logic [SIZE_Y_W-1:0]     size_y_reg;
    logic [SIZE_Z_W-1:0]     size_z_reg;

    opcode_t                 op_reg;
    logic                    oob_reg;
    logic [ROW_W-1:0]        row_reg;
    logic [3:0]              x_word_reg;
    logic [WORD_SEL_W-1:0]   x_bit_reg;
    logic [AW-1:0]           addr_reg;
    logic [WORD_W-1:0]       rdata_reg;
    logic [AW-1:0]           clr_addr_reg;
    logic                    clr_reply_reg;

    logic                    m_valid_reg;
    logic                    m_status_reg;
    logic                    m_bit_value_reg;

    logic [WORD_W-1:0]       mem [DEPTH];

    logic                    out_free;
    logic                    reply_load;
    logic                    s_accept;
    logic                    in_oob;
    logic [ROW_W-1:0]        row_next;
    logic [7:0]              size_x_round;
    logic [ROW_WORDS_W-1:0]  row_words;
    logic [WADDR_W-1:0]      waddr_full;
    logic [AW-1:0]           addr_next;
    logic                    point_write;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [WORD_W-1:0]       wr_data;
    logic [WORD_W-1:0]       bit_mask;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) || ((state_reg == ST_RMW) && out_free);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign reply_load = out_free && ((state_reg == ST_RMW)
                     || ((state_reg == ST_CLEAR) && (clr_addr_reg == LAST_ADDR)
                         && clr_reply_reg));

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_bit_value = m_bit_value_reg;

    assign in_oob = (s_coord_x >= {1'b0, size_x_reg})
                 || (s_coord_y >= {1'b0, size_y_reg})
                 || (s_coord_z >= {3'b000, size_z_reg});

    assign row_next = ROW_W'(size_y_reg) * ROW_W'(s_coord_z[SIZE_Z_W-1:0])
                    + ROW_W'(s_coord_y[SIZE_Y_W-1:0]);

    assign size_x_round = {1'b0, size_x_reg} + 8'd7;
    assign row_words    = size_x_round[7:3];
    assign waddr_full   = WADDR_W'(row_reg) * WADDR_W'(row_words) + WADDR_W'(x_word_reg);
    assign addr_next    = AW'(waddr_full);

    assign bit_mask    = WORD_W'(1) << x_bit_reg;
    assign point_write = (state_reg == ST_RMW) && out_free && !oob_reg
                      && ((op_reg == OP_SET) || (op_reg == OP_CLEAR));
    assign wr_en       = (state_reg == ST_CLEAR) || point_write;
    assign wr_addr     = (state_reg == ST_CLEAR) ? clr_addr_reg : addr_reg;

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            wr_data = '0;
        end else if (op_reg == OP_SET) begin
            wr_data = rdata_reg | bit_mask;
        end else begin
            wr_data = rdata_reg & ~bit_mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_ADDR) begin
            rdata_reg <= mem[addr_next];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= SIZE_X_INIT;
            size_y_reg <= SIZE_Y_INIT;
            size_z_reg <= SIZE_Z_INIT;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SIZE_X: begin
                    size_x_reg <= (32'(cfg_data[SIZE_X_W-1:0]) > MAX_SIZE_X)
                                ? SIZE_X_W'(MAX_SIZE_X) : cfg_data[SIZE_X_W-1:0];
                end
                CFG_SIZE_Y: begin
                    size_y_reg <= (32'(cfg_data[SIZE_Y_W-1:0]) > MAX_SIZE_Y)
                                ? SIZE_Y_W'(MAX_SIZE_Y) : cfg_data[SIZE_Y_W-1:0];
                end
                CFG_SIZE_Z: begin
                    size_z_reg <= (32'(cfg_data[SIZE_Z_W-1:0]) > MAX_SIZE_Z)
                                ? SIZE_Z_W'(MAX_SIZE_Z) : cfg_data[SIZE_Z_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_ADDR) begin
            addr_reg <= addr_next;
        end
        if (s_accept) begin
            op_reg     <= opcode_t'(s_opcode);
            oob_reg    <= in_oob;
            row_reg    <= row_next;
            x_word_reg <= s_coord_x[6:3];
            x_bit_reg  <= s_coord_x[WORD_SEL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            clr_reply_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_ready && !reply_load) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE, ST_RMW: begin
                    if ((state_reg == ST_RMW) && out_free) begin
                        m_valid_reg     <= 1'b1;
                        m_status_reg    <= oob_reg;
                        m_bit_value_reg <= !oob_reg && (op_reg == OP_GET)
                                         && rdata_reg[x_bit_reg];
                    end
                    if (s_accept) begin
                        if (s_opcode == OP_CLEAR_ALL) begin
                            state_reg     <= ST_CLEAR;
                            clr_addr_reg  <= '0;
                            clr_reply_reg <= 1'b1;
                        end else begin
                            state_reg <= ST_ADDR;
                        end
                    end else if ((state_reg == ST_RMW) && out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_ADDR: begin
                    state_reg <= ST_RMW;
                end
                ST_CLEAR: begin
                    if (clr_addr_reg != LAST_ADDR) begin
                        clr_addr_reg <= clr_addr_reg + AW'(1);
                    end else if (!clr_reply_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (out_free) begin
                        m_valid_reg     <= 1'b1;
                        m_status_reg    <= 1'b0;
                        m_bit_value_reg <= 1'b0;
                        clr_reply_reg   <= 1'b0;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[design/p3bv_checker.sv]
// ----------------------------------------------------------------------------
// p3bv_checker
// Port-level checks for the padded 3D bit volume store.
// ----------------------------------------------------------------------------
module p3bv_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_status,
    input logic m_bit_value
);

    // A result that is not taken stays with the same payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_bit_value))
        else $error("result changed while stalled");

    // An out-of-range result never carries a stored bit.
    a_oob_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> !m_bit_value)
        else $error("bit value set on out-of-range result");

    // Acceptance leads to ST_ADDR or ST_CLEAR; no transfer follows directly.
    a_accept_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted in consecutive cycles");

    // The memory is swept after reset before any command is taken.
    a_reset_sweep: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_ready)
        else $error("input ready right after reset");

endmodule

bind padded_3d_bit_volume p3bv_checker u_p3bv_checker (.*);

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the padded 3D bit volume store. A local copy of the
// voxel store and the geometry predicts the reply to every accepted command,
// and each reply transfer is checked in order. Directed tests cover the
// corners, out-of-range coordinates, clear-all and the register special
// cases; random traffic then runs over several geometries with bursty
// commands and a stalling reply channel.
// ----------------------------------------------------------------------------
module tb;
    import p3bv_pkg::*;

    localparam int PAD_X_MAX = ((MAX_SIZE_X_DEF + 7) / 8) * 8;
    localparam int STORE_BITS = PAD_X_MAX * MAX_SIZE_Y_DEF * MAX_SIZE_Z_DEF;
    localparam int STALL_LIMIT = 40000;
    localparam int RANDOM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 215;

    typedef struct packed {
        logic status;
        logic bit_value;
    } reply_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } voxel_pos_t;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_RHYTHM
    } rx_mode_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [OPCODE_W-1:0]    s_opcode = OP_SET;
    logic [COORD_W-1:0]     s_coord_x = '0;
    logic [COORD_W-1:0]     s_coord_y = '0;
    logic [COORD_W-1:0]     s_coord_z = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_status;
    logic                   m_bit_value;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_SIZE_X;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic [STORE_BITS-1:0] voxel_store;
    int unsigned size_x_eff;
    int unsigned size_y_eff;
    int unsigned size_z_eff;
    reply_t awaited_replies[$];
    voxel_pos_t written_pos[$];
    reply_t want_reply;
    int mismatch_count = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int stall_span = 0;
    rx_mode_t stall_mode = RX_OPEN;
    logic [2:0] stall_phase = '0;

    padded_3d_bit_volume u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_coord_x   (s_coord_x),
        .s_coord_y   (s_coord_y),
        .s_coord_z   (s_coord_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_bit_value (m_bit_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int unsigned clamp_size(int unsigned v, int unsigned max_v);
        return (v > max_v) ? max_v : v;
    endfunction

    function automatic reply_t predict_voxel_reply(opcode_t op, logic [COORD_W-1:0] x,
                                                   logic [COORD_W-1:0] y,
                                                   logic [COORD_W-1:0] z);
        reply_t reply;
        int unsigned row_len;
        int unsigned bit_addr;
        reply = '0;
        if (op == OP_CLEAR_ALL) begin
            voxel_store = '0;
        end else if (x >= size_x_eff || y >= size_y_eff || z >= size_z_eff) begin
            reply.status = 1'b1;
        end else begin
            row_len = ((size_x_eff + 7) / 8) * 8;
            bit_addr = x + row_len * (y + size_y_eff * z);
            case (op)
                OP_SET: begin
                    voxel_store[bit_addr] = 1'b1;
                end
                OP_CLEAR: begin
                    voxel_store[bit_addr] = 1'b0;
                end
                default: begin
                    reply.bit_value = voxel_store[bit_addr];
                end
            endcase
        end
        return reply;
    endfunction

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_config(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_SIZE_X: begin
                size_x_eff = clamp_size(32'(data), MAX_SIZE_X_DEF);
            end
            CFG_SIZE_Y: begin
                size_y_eff = clamp_size(32'(data), MAX_SIZE_Y_DEF);
            end
            CFG_SIZE_Z: begin
                size_z_eff = clamp_size(32'(data[SIZE_Z_W-1:0]), MAX_SIZE_Z_DEF);
            end
            default: begin
            end
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_geometry(logic [CFG_DATA_W-1:0] sx, logic [CFG_DATA_W-1:0] sy,
                                logic [CFG_DATA_W-1:0] sz);
        write_config(CFG_SIZE_X, sx);
        write_config(CFG_SIZE_Y, sy);
        write_config(CFG_SIZE_Z, sz);
    endtask

    // The sender works in bursts; a burst of 96 gives a long stretch with no gaps.
    task automatic send_voxel_cmd(opcode_t op, logic [COORD_W-1:0] x,
                                  logic [COORD_W-1:0] y, logic [COORD_W-1:0] z);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 5) == 0) ? 96 : $urandom_range(1, 20);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        burst_left--;
        s_opcode <= op;
        s_coord_x <= x;
        s_coord_y <= y;
        s_coord_z <= z;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        awaited_replies.push_back(predict_voxel_reply(op, x, y, z));
    endtask

    task automatic test_point_access();
        send_voxel_cmd(OP_GET, 8'd0, 8'd0, 8'd0);
        send_voxel_cmd(OP_SET, 8'd0, 8'd0, 8'd0);
        send_voxel_cmd(OP_GET, 8'd0, 8'd0, 8'd0);
        send_voxel_cmd(OP_SET, 8'd63, 8'd63, 8'd15);
        send_voxel_cmd(OP_GET, 8'd63, 8'd63, 8'd15);
        send_voxel_cmd(OP_GET, 8'd62, 8'd63, 8'd15);
        send_voxel_cmd(OP_CLEAR, 8'd0, 8'd0, 8'd0);
        send_voxel_cmd(OP_GET, 8'd0, 8'd0, 8'd0);
    endtask

    task automatic test_out_of_range();
        send_voxel_cmd(OP_SET, 8'd64, 8'd0, 8'd0);
        send_voxel_cmd(OP_CLEAR, 8'd0, 8'd64, 8'd0);
        send_voxel_cmd(OP_CLEAR, 8'd63, 8'd63, 8'd16);
        send_voxel_cmd(OP_GET, 8'd255, 8'd255, 8'd255);
        send_voxel_cmd(OP_GET, 8'd63, 8'd63, 8'd15);
    endtask

    task automatic test_clear_all();
        send_voxel_cmd(OP_CLEAR_ALL, 8'd255, 8'd255, 8'd255);
        send_voxel_cmd(OP_GET, 8'd63, 8'd63, 8'd15);
    endtask

    task automatic test_config_cases();
        // Sizes above the maximum saturate; size_z keeps only its low bits.
        set_geometry(7'h7F, 7'h7F, 7'h7F);
        send_voxel_cmd(OP_SET, 8'd8, 8'd0, 8'd0);
        write_config(CFG_UNUSED, 7'h55);
        send_voxel_cmd(OP_GET, 8'd8, 8'd0, 8'd0);
        // A narrower row maps the same stored bit to a new coordinate.
        write_config(CFG_SIZE_X, 7'd8);
        send_voxel_cmd(OP_GET, 8'd0, 8'd1, 8'd0);
        write_config(CFG_SIZE_X, 7'd1);
        send_voxel_cmd(OP_GET, 8'd0, 8'd1, 8'd0);
        send_voxel_cmd(OP_GET, 8'd1, 8'd0, 8'd0);
        write_config(CFG_SIZE_X, 7'd0);
        send_voxel_cmd(OP_GET, 8'd0, 8'd0, 8'd0);
        write_config(CFG_SIZE_X, 7'd64);
        write_config(CFG_SIZE_Z, 7'h20);
        send_voxel_cmd(OP_SET, 8'd0, 8'd0, 8'd0);
        write_config(CFG_SIZE_Z, 7'd16);
        write_config(CFG_SIZE_Y, 7'd0);
        send_voxel_cmd(OP_GET, 8'd8, 8'd0, 8'd0);
        set_geometry(7'd64, 7'd64, 7'd16);
    endtask

    task automatic test_random_traffic();
        voxel_pos_t pos;
        opcode_t op;
        int pick;
        int axis;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: set_geometry(7'd1, 7'd1, 7'd1);
                1: set_geometry(7'd64, 7'd64, 7'd16);
                2: set_geometry(7'h7F, 7'd1, 7'h1F);
                default: set_geometry(CFG_DATA_W'($urandom_range(1, 64)),
                                      CFG_DATA_W'($urandom_range(1, 64)),
                                      CFG_DATA_W'($urandom_range(1, 16)));
            endcase
            written_pos.delete();
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2) begin
                    wait_idle();
                end
                pick = $urandom_range(0, 99);
                pos.x = COORD_W'($urandom_range(0, size_x_eff - 1));
                pos.y = COORD_W'($urandom_range(0, size_y_eff - 1));
                pos.z = COORD_W'($urandom_range(0, size_z_eff - 1));
                if (pick < 1) begin
                    op = OP_CLEAR_ALL;
                    pos = voxel_pos_t'(24'($urandom()));
                end else if (pick < 11) begin
                    op = opcode_t'($urandom_range(0, 2));
                    axis = $urandom_range(0, 2);
                    case (axis)
                        0: pos.x = COORD_W'($urandom_range(size_x_eff, 255));
                        1: pos.y = COORD_W'($urandom_range(size_y_eff, 255));
                        default: pos.z = COORD_W'($urandom_range(size_z_eff, 255));
                    endcase
                end else if (pick < 41) begin
                    op = OP_SET;
                end else begin
                    op = (pick < 56) ? OP_CLEAR : OP_GET;
                    if (written_pos.size() != 0 && $urandom_range(0, 2) != 0) begin
                        pos = written_pos[$urandom_range(0, written_pos.size() - 1)];
                    end
                end
                send_voxel_cmd(op, pos.x, pos.y, pos.z);
                if (op == OP_SET && pick >= 11) begin
                    written_pos.push_back(pos);
                    if (written_pos.size() > 32) begin
                        void'(written_pos.pop_front());
                    end
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        stall_phase <= stall_phase + 1'b1;
        if (stall_span == 0) begin
            stall_mode <= rx_mode_t'($urandom_range(0, 3));
            stall_span <= $urandom_range(16, 200);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            RX_OPEN: m_ready <= 1'b1;
            RX_COIN: m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (stall_phase < 3'd5);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (awaited_replies.size() == 0) begin
                $error("reply transfer with none expected: status %0b, bit_value %0b",
                       m_status, m_bit_value);
                mismatch_count++;
            end else begin
                want_reply = awaited_replies.pop_front();
                if (m_status !== want_reply.status) begin
                    $error("status: expected %0b, actual %0b", want_reply.status, m_status);
                    mismatch_count++;
                end
                if (m_bit_value !== want_reply.bit_value) begin
                    $error("bit_value: expected %0b, actual %0b",
                           want_reply.bit_value, m_bit_value);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        size_x_eff = clamp_size(SIZE_X_RST, MAX_SIZE_X_DEF);
        size_y_eff = clamp_size(SIZE_Y_RST, MAX_SIZE_Y_DEF);
        size_z_eff = clamp_size(SIZE_Z_RST, MAX_SIZE_Z_DEF);
        voxel_store = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_point_access();
        test_out_of_range();
        test_clear_all();
        test_config_cases();
        test_random_traffic();
        wait_idle();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && awaited_replies.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
